FILE: design/psd_pkg.sv
`timescale 1ns / 1ps

package psd_pkg;

  // Configuration register indexes
  localparam logic CFG_PREAMBLE = 1'b0;
  localparam logic CFG_MAX_LEN  = 1'b1;

  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] PREAMBLE_RST = 16'hFFF0;
  localparam logic [7:0]  MAX_LEN_RST  = 8'hFF;

  // group_count: 0 = hunting, 1..9 = bits of the current group
  localparam logic [3:0] GROUP_HUNT = 4'd0;
  localparam logic [3:0] GROUP_FIRST = 4'd1;
  localparam logic [3:0] GROUP_BITS = 4'd9;

  localparam int unsigned LEAD_BIT = 8;

  typedef struct packed {
    logic       last_byte;
    logic [7:0] packet_length;
    logic [7:0] byte_index;
    logic [7:0] data_byte;
  } psd_result_t;

endpackage

FILE: design/preamble_sync_packet_deframer.sv
`timescale 1ns / 1ps

// Channel  Dir  Signals                         Contents
// in       in   in_tvalid/in_tready/in_tdata    tdata[0] rx_bit
// out      out  out_tvalid/out_tready/out_tdata tdata: data_byte, byte_index,
//                 out_tlast                       packet_length; tlast last_byte
// cfg      in   cfg_we/cfg_addr/cfg_wdata       0 preamble_pattern, 1 max_length
//
// One bit per cycle while in_tready is high: each transaction updates the deframer state
// in the cycle it is accepted, and any byte it completes lands in the output register.
// A byte appears on out in the cycle after the bit that completes its group.
// Reset is synchronous, active low; it clears the deframer to hunting and
// restores the register defaults.
// A stalled output holds in_tready low only while a byte is waiting.
module preamble_sync_packet_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [0] rx_bit, [7:1] zero
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // [7:0] data_byte,
                                                     // [15:8] byte_index,
                                                     // [23:16] packet_length
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [psd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [psd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import psd_pkg::*;

  logic        adv;
  logic        res_valid;
  psd_result_t res;
  psd_result_t res_q;

  // advance the deframer on every accepted bit
  assign adv = in_tvalid && in_tready;

  psd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .adv       (adv),
    .rx_bit    (in_tdata[0]),
    .res_valid (res_valid),
    .res       (res)
  );

  psd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_en   (in_tvalid),
    .res_valid (res_valid),
    .res       (res),
    .valid     (out_tvalid),
    .res_q     (res_q),
    .ready     (out_tready),
    .load_ok   (in_tready)
  );

  assign out_tdata = {res_q.packet_length, res_q.byte_index, res_q.data_byte};
  assign out_tlast = res_q.last_byte;

endmodule

FILE: design/psd_core.sv
`timescale 1ns / 1ps

module psd_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [psd_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [psd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 adv,
  input  logic                                 rx_bit,
  output logic                                 res_valid,
  output psd_pkg::psd_result_t                 res
);
  import psd_pkg::*;

  logic [15:0] preamble_r;
  logic [7:0]  max_len_r;
  logic [15:0] bit_shift_r;
  logic [3:0]  group_count_r;
  logic        header_pending_r;
  logic [7:0]  announced_len_r;
  logic [7:0]  bytes_rcvd_r;

  logic [15:0] bit_shift_nxt;
  logic [3:0]  group_count_nxt;
  logic        header_pending_nxt;
  logic [7:0]  announced_len_nxt;
  logic [7:0]  bytes_rcvd_nxt;
  logic [7:0]  group_byte;
  logic [7:0]  rcvd_inc;

  assign bit_shift_nxt = {bit_shift_r[14:0], rx_bit};
  assign group_byte    = bit_shift_nxt[7:0];
  assign rcvd_inc      = bytes_rcvd_r + 8'd1;

  always_comb begin
    group_count_nxt    = group_count_r;
    header_pending_nxt = header_pending_r;
    announced_len_nxt  = announced_len_r;
    bytes_rcvd_nxt     = bytes_rcvd_r;
    res_valid          = 1'b0;
    res.data_byte      = group_byte;
    res.byte_index     = bytes_rcvd_r;
    res.packet_length  = announced_len_r;
    res.last_byte      = (rcvd_inc == announced_len_r);
    priority if (group_count_r == GROUP_HUNT) begin
      if (bit_shift_nxt == preamble_r) begin
        header_pending_nxt = 1'b1;
        group_count_nxt    = GROUP_FIRST;
      end
    end else if (group_count_r < GROUP_BITS) begin
      group_count_nxt = group_count_r + 4'd1;
    end else if (bit_shift_nxt[LEAD_BIT]) begin
      // leading one: drop sync
      group_count_nxt    = GROUP_HUNT;
      header_pending_nxt = 1'b1;
    end else begin
      group_count_nxt = GROUP_FIRST;
      if (header_pending_r) begin
        if (group_byte > max_len_r) begin
          group_count_nxt = GROUP_HUNT;
        end else begin
          announced_len_nxt  = group_byte;
          bytes_rcvd_nxt     = 8'd0;
          header_pending_nxt = 1'b0;
        end
      end else if (bytes_rcvd_r < announced_len_r) begin
        res_valid      = 1'b1;
        bytes_rcvd_nxt = rcvd_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preamble_r <= PREAMBLE_RST;
      max_len_r  <= MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PREAMBLE: preamble_r <= cfg_wdata;
        CFG_MAX_LEN:  max_len_r  <= cfg_wdata[7:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_shift_r      <= 16'd0;
      group_count_r    <= GROUP_HUNT;
      header_pending_r <= 1'b1;
      announced_len_r  <= 8'd0;
      bytes_rcvd_r     <= 8'd0;
    end else if (adv) begin
      bit_shift_r      <= bit_shift_nxt;
      group_count_r    <= group_count_nxt;
      header_pending_r <= header_pending_nxt;
      announced_len_r  <= announced_len_nxt;
      bytes_rcvd_r     <= bytes_rcvd_nxt;
    end
  end

endmodule

FILE: design/psd_out_reg.sv
`timescale 1ns / 1ps

module psd_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load_en,
  input  logic                 res_valid,
  input  psd_pkg::psd_result_t res,
  output logic                 valid,
  output psd_pkg::psd_result_t res_q,
  input  logic                 ready,
  output logic                 load_ok
);
  import psd_pkg::*;

  logic        valid_r;
  psd_result_t res_r;

  // register free or draining this cycle
  assign load_ok = !valid_r || ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ok) begin
      valid_r <= load_en && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && load_en && res_valid) begin
      res_r <= res;
    end
  end

  assign valid = valid_r;
  assign res_q = res_r;

endmodule

FILE: design/psd_checker.sv
`timescale 1ns / 1ps

module psd_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // a waiting byte stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output transaction dropped while stalled");

  // a new byte only follows an accepted bit
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("output transaction without input transaction");

  // index always below the announced length
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:8] < out_tdata[23:16])
    else $error("byte index beyond packet length");

  // last flag marks exactly the final index
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == ((out_tdata[15:8] + 8'd1) == out_tdata[23:16])))
    else $error("last flag inconsistent with index");

  // with the output register empty, the input never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

endmodule

bind preamble_sync_packet_deframer psd_assertions u_psd_assertions (.*);

FILE: bench/psd_checker.sv
`timescale 1ns / 1ps

// Watches the deframer's channels, predicts the byte stream and compares it.
module psd_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [7:0]                     in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [23:0]                    out_tdata,
  input  logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [psd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [psd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             outstanding,
  output int                             bytes_predicted,
  output int                             packets_closed
);
  import psd_pkg::*;

  localparam int REPORT_CAP = 30;

  logic [15:0] sync_word;
  logic [7:0]  len_limit;
  logic [15:0] shreg;
  logic [3:0]  bit_pos;
  logic        awaiting_header;
  logic [7:0]  pkt_len;
  logic [7:0]  pkt_count;

  psd_result_t awaited_bytes[$];
  psd_result_t want;
  int          errors = 0;
  int          predicted = 0;
  int          closed = 0;
  bit          field_bad;

  // Advance the deframer by one channel bit; queue the byte it completes.
  task automatic deframe_bit(input logic b);
    psd_result_t r;
    shreg = {shreg[14:0], b};
    if (bit_pos == GROUP_HUNT) begin
      if (shreg == sync_word) begin
        awaiting_header = 1'b1;
        bit_pos = GROUP_FIRST;
      end
    end else if (bit_pos < GROUP_BITS) begin
      bit_pos = bit_pos + 4'd1;
    end else if (shreg[LEAD_BIT]) begin
      bit_pos = GROUP_HUNT;
      awaiting_header = 1'b1;
    end else begin
      bit_pos = GROUP_FIRST;
      if (awaiting_header) begin
        if (shreg[7:0] > len_limit) begin
          bit_pos = GROUP_HUNT;
        end else begin
          pkt_len = shreg[7:0];
          pkt_count = 8'd0;
          awaiting_header = 1'b0;
        end
      end else if (pkt_count < pkt_len) begin
        r.data_byte = shreg[7:0];
        r.byte_index = pkt_count;
        r.packet_length = pkt_len;
        pkt_count = pkt_count + 8'd1;
        r.last_byte = (pkt_count == pkt_len);
        awaited_bytes.push_back(r);
        predicted++;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      field_bad = 1'b1;
      if (errors < REPORT_CAP)
        $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sync_word = PREAMBLE_RST;
      len_limit = MAX_LEN_RST;
      shreg = 16'd0;
      bit_pos = GROUP_HUNT;
      awaiting_header = 1'b1;
      pkt_len = 8'd0;
      pkt_count = 8'd0;
      awaited_bytes.delete();
    end else begin
      // compare first, so a byte cannot match a bit taken at the same edge
      if (out_tvalid && out_tready) begin
        if (awaited_bytes.size() == 0) begin
          if (errors < REPORT_CAP)
            $display("%0t: no byte expected, got data %0h last %0b", $time,
                     out_tdata, out_tlast);
          errors++;
        end else begin
          want = awaited_bytes.pop_front();
          field_bad = 1'b0;
          check_field("data_byte", want.data_byte, out_tdata[7:0]);
          check_field("byte_index", want.byte_index, out_tdata[15:8]);
          check_field("packet_length", want.packet_length, out_tdata[23:16]);
          check_field("last_byte", {7'd0, want.last_byte}, {7'd0, out_tlast});
          if (field_bad) errors++;
          if (want.last_byte) closed++;
        end
      end
      // a bit taken at a write edge still sees the old register value
      if (in_tvalid && in_tready) deframe_bit(in_tdata[0]);
      if (cfg_we) begin
        case (cfg_addr)
          CFG_PREAMBLE: sync_word = cfg_wdata;
          CFG_MAX_LEN:  len_limit = cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
    mismatches      <= errors;
    outstanding     <= awaited_bytes.size();
    bytes_predicted <= predicted;
    packets_closed  <= closed;
  end

endmodule

FILE: bench/preamble_sync_packet_deframer_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict; all prediction and comparison lives in psd_checker.
module preamble_sync_packet_deframer_test;
  import psd_pkg::*;

  localparam int RANDOM_BITS = 150;
  localparam int MIN_BYTES   = 48;
  localparam int MAX_PHASES  = 80;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'd0;     // [0] rx_bit, [7:1] zero
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;           // [7:0] data_byte, [15:8] byte_index,
                                              // [23:16] packet_length
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int bytes_predicted;
  int packets_closed;

  // Bookkeeping for the sender side.
  logic [15:0] cur_sync = PREAMBLE_RST;
  logic [7:0]  cur_limit = MAX_LEN_RST;
  int          bits_sent = 0;
  int          burst_left = 0;
  int          settings_run = 1;
  int          rx_cycle = 0;

  always #6 clk = ~clk;

  preamble_sync_packet_deframer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  psd_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .outstanding(outstanding),
    .bytes_predicted(bytes_predicted), .packets_closed(packets_closed)
  );

  // Receiver: cycle through always-ready, coin-flip, mostly-stalled and a
  // fixed 3-of-7 stall pattern, so backpressure lands on every group phase.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 160) % 4)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      2: out_tready <= ($urandom_range(0, 4) == 0);
      default: out_tready <= ((rx_cycle % 7) >= 3);
    endcase
  end

  // Send one bit as one transaction. Bursts of random length, with random
  // gaps between them; an occasional long burst runs with no idling at all.
  task automatic push_bit(input logic b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bits_sent++;
  endtask

  // Send the low n bits of v, oldest (most significant) first.
  task automatic push_field(input logic [15:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) push_bit(v[i]);
  endtask

  task automatic push_group(input logic lead, input logic [7:0] payload);
    push_field({7'd0, lead, payload}, 9);
  endtask

  // Payload byte with the extremes favored.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Preamble, header, a run of lead-0 groups, then a lead-1 group to drop
  // sync. Fewer groups than the header aborts the packet; more are ignored.
  task automatic send_frame(input logic [7:0] header, input int groups);
    push_field(cur_sync, 16);
    push_group(1'b0, header);
    repeat (groups) push_group(1'b0, pick_byte());
    push_group(1'b1, 8'($urandom));
  endtask

  // Hold the sender until every predicted byte has been taken, then let a group
  // that completes with no byte settle too.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sync(input logic [15:0] value);
    cur_sync = value;
    write_reg(CFG_PREAMBLE, value);
  endtask

  // Upper data bits are junk on purpose; only the low byte is the register.
  task automatic set_limit(input logic [7:0] value);
    cur_limit = value;
    write_reg(CFG_MAX_LEN, {8'($urandom), value});
  endtask

  initial begin
    int directed_bits;
    int phase;
    int kind;
    int len;
    int wait_cycles;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default settings. Two-byte packet with both extreme bytes,
    // then a group past the length (ignored) and a lead-1 group (drop).
    push_field(PREAMBLE_RST, 16);
    push_group(1'b0, 8'd2);
    push_group(1'b0, 8'h00);
    push_group(1'b0, 8'hFF);
    push_group(1'b0, 8'h3C);
    push_group(1'b1, 8'h00);
    // Zero length: header accepted, nothing emitted, later group ignored.
    send_frame(8'd0, 1);
    // Abort mid-packet, then a fresh packet reusing the hunt.
    send_frame(8'd4, 1);
    send_frame(8'd1, 1);

    // Preamble seen while synchronized must not restart the packet.
    settle();
    set_sync(16'h00FF);
    settings_run++;
    push_field(cur_sync, 16);
    push_group(1'b0, 8'd3);
    push_field(cur_sync, 16);
    push_field(16'h0000, 11);
    push_group(1'b1, 8'hA5);

    // Tightest limit: any nonzero header drops sync, zero still passes.
    settle();
    set_limit(8'd0);
    settings_run++;
    send_frame(8'd1, 1);
    send_frame(8'd255, 0);
    send_frame(8'd0, 2);

    // Widest limit and an all-ones sync word: a header at the widest length,
    // cut short after a run of bytes.
    settle();
    set_limit(8'd255);
    set_sync(16'hFFFF);
    settings_run++;
    send_frame(8'd255, 24);

    // All-zero sync word.
    settle();
    set_sync(16'h0000);
    settings_run++;
    send_frame(8'd3, 3);

    directed_bits = bits_sent;

    // Random: each phase picks new settings, then sends a handful of frames,
    // mostly well formed with a share of oversize headers, aborts and noise.
    phase = 0;
    while ((bits_sent - directed_bits < RANDOM_BITS || bytes_predicted < MIN_BYTES)
           && phase < MAX_PHASES) begin
      settle();
      case ($urandom_range(0, 4))
        0: set_sync(PREAMBLE_RST);
        1: set_sync(16'h0000);
        2: set_sync(16'hFFFF);
        default: set_sync(16'($urandom));
      endcase
      case ($urandom_range(0, 5))
        0: set_limit(8'd255);
        1: set_limit(8'd0);
        2: set_limit(8'($urandom));
        default: set_limit(8'($urandom_range(2, 8)));
      endcase
      settings_run++;
      repeat (4) begin
        push_field(16'($urandom), $urandom_range(0, 6));
        kind = $urandom_range(0, 9);
        len = $urandom_range(0, (cur_limit < 6) ? cur_limit : 6);
        if (kind == 0 && cur_limit != 8'd255) begin
          send_frame(8'($urandom_range(cur_limit + 1, 255)), 2);
        end else if (kind == 1) begin
          send_frame(8'(len + 2), len);
        end else if (kind == 2) begin
          push_field(16'($urandom), 16);
          push_field(16'($urandom), 9);
        end else begin
          send_frame(8'(len), len + $urandom_range(0, 2));
        end
      end
      phase++;
    end

    // Drain, with a bound so a lost byte still ends in a verdict.
    in_tvalid <= 1'b0;
    wait_cycles = 0;
    @(posedge clk);
    while (outstanding != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);

    if (outstanding != 0)
      $display("%0t: %0d predicted bytes never arrived", $time, outstanding);
    $display("Sent %0d channel bits under %0d register settings.",
             bits_sent, settings_run);
    $display("Compared %0d payload bytes, %0d of them closing a packet.",
             bytes_predicted - outstanding, packets_closed);
    if (mismatches == 0 && outstanding == 0) begin
      $display("preamble_sync_packet_deframer: match");
    end else begin
      $display("preamble_sync_packet_deframer: mismatch");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("preamble_sync_packet_deframer: mismatch");
    $finish;
  end

endmodule
